/* design/stt_pkg.sv */
// Shared types, token codes and helper functions for the source text tokenizer.
package stt_pkg;

   localparam int MAX_TEXT_BYTES_DEF = 65536;
   localparam int KEYWORD_SPAN_DEF   = 6;

   localparam int BYTE_W = 8;
   localparam int POS_W  = 16;
   localparam int KIND_W = 5;
   localparam int LEN_W  = 16;

   // Keywords compared against the first bytes of an identifier
   localparam int KW_COUNT   = 8;
   localparam int KW_MAX_LEN = 6;

   // Token kinds
   localparam logic [KIND_W-1:0] K_LPAREN    = 5'd0;
   localparam logic [KIND_W-1:0] K_RPAREN    = 5'd1;
   localparam logic [KIND_W-1:0] K_LBRACE    = 5'd2;
   localparam logic [KIND_W-1:0] K_RBRACE    = 5'd3;
   localparam logic [KIND_W-1:0] K_COMMA     = 5'd4;
   localparam logic [KIND_W-1:0] K_DOT       = 5'd5;
   localparam logic [KIND_W-1:0] K_MINUS     = 5'd6;
   localparam logic [KIND_W-1:0] K_PLUS      = 5'd7;
   localparam logic [KIND_W-1:0] K_SEMICOLON = 5'd8;
   localparam logic [KIND_W-1:0] K_SLASH     = 5'd9;
   localparam logic [KIND_W-1:0] K_STAR      = 5'd10;
   localparam logic [KIND_W-1:0] K_BANG      = 5'd11;
   localparam logic [KIND_W-1:0] K_EQUAL     = 5'd13;
   localparam logic [KIND_W-1:0] K_GREATER   = 5'd15;
   localparam logic [KIND_W-1:0] K_LESS      = 5'd17;
   localparam logic [KIND_W-1:0] K_IDENT     = 5'd19;
   localparam logic [KIND_W-1:0] K_STRING    = 5'd20;
   localparam logic [KIND_W-1:0] K_NUMBER    = 5'd21;
   localparam logic [KIND_W-1:0] K_VAR       = 5'd22;
   localparam logic [KIND_W-1:0] K_ERROR     = 5'd30;
   localparam logic [KIND_W-1:0] K_EOF       = 5'd31;

   // Keyword text, first character in the low byte (literals read backwards)
   localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
      48'("rav"), 48'("eslaf"), 48'("nf"), 48'("nruter"),
      48'("eurt"), 48'("lin"), 48'("fi"), 48'("tnirp")
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd3, 3'd5, 3'd2, 3'd6, 3'd4, 3'd3, 3'd2, 3'd5
   };

   // Queue of per-byte token bundles between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int BUNDLE_MAX  = 3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  offset;
      logic [LEN_W-1:0]  length;
   } token_type;

   typedef struct packed {
      logic [1:0]                 count;
      token_type [BUNDLE_MAX-1:0] toks;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic token_type make_token(input logic [KIND_W-1:0] kind,
                                            input logic [POS_W-1:0]  offset,
                                            input logic [LEN_W-1:0]  length);
      token_type t;
      t.kind   = kind;
      t.offset = offset;
      t.length = length;
      return t;
   endfunction

   // Distance from one position to another, zero if negative, capped at the length range
   function automatic logic [LEN_W-1:0] span_len(input logic [POS_W:0] from_pos,
                                                 input logic [POS_W:0] to_pos);
      logic [POS_W:0] diff;
      diff = (to_pos > from_pos) ? (to_pos - from_pos) : '0;
      return diff[POS_W] ? {LEN_W{1'b1}} : diff[LEN_W-1:0];
   endfunction

   // Keyword lookup at exact length on the first identifier bytes
   function automatic logic [KIND_W-1:0] classify_ident(
      input logic [8*KW_MAX_LEN-1:0] prefix,
      input logic [LEN_W-1:0]        len);
      logic [KIND_W-1:0] kind;
      logic              hit;
      kind = K_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         hit = (len == LEN_W'(KW_LEN[k]));
         for (int i = 0; i < KW_MAX_LEN; i++) begin
            if ((LEN_W'(i) < len) && (prefix[8*i +: 8] != KW_TEXT[k][8*i +: 8])) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            kind = K_VAR + KIND_W'(k);
         end
      end
      return kind;
   endfunction

endpackage

/* design/stt_ifs.sv */
// Valid/ready channel interfaces for source bytes and tokens.
interface stt_req_if;
   logic                      valid;
   logic                      ready;
   logic [stt_pkg::BYTE_W-1:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

interface stt_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [stt_pkg::KIND_W-1:0] token_kind;
   logic [stt_pkg::POS_W-1:0]  token_offset;
   logic [stt_pkg::LEN_W-1:0]  token_length;
   logic                       last_of_run;

   modport source (output valid, output token_kind, output token_offset,
                   output token_length, output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input token_offset,
                   input token_length, input last_of_run, output ready);
endinterface

/* design/stt_front.sv */
// Scanner front end: classifies each byte and builds the bundle of tokens it causes.
module stt_front #(
   parameter int MAX_TEXT_BYTES = stt_pkg::MAX_TEXT_BYTES_DEF,
   parameter int KEYWORD_SPAN   = stt_pkg::KEYWORD_SPAN_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   stt_req_if.sink                 req_if,
   input  stt_pkg::queue_status_type q_status,
   output logic                    push,
   output stt_pkg::bundle_type     push_bundle
);

   localparam int KW_IDX_W = $clog2(KEYWORD_SPAN);
   localparam logic [stt_pkg::POS_W-1:0] POS_LIMIT =
      ((MAX_TEXT_BYTES - 1) < 65535) ? stt_pkg::POS_W'(MAX_TEXT_BYTES - 1)
                                     : {stt_pkg::POS_W{1'b1}};

   typedef enum logic [6:0] {
      MODE_IDLE    = 7'b0000001,
      MODE_OPER    = 7'b0000010,
      MODE_IDENT   = 7'b0000100,
      MODE_INT     = 7'b0001000,
      MODE_DOTWAIT = 7'b0010000,
      MODE_FRAC    = 7'b0100000,
      MODE_STRING  = 7'b1000000
   } mode_type;

   localparam logic [1:0] OP_EQ   = 2'd0;
   localparam logic [1:0] OP_BANG = 2'd1;
   localparam logic [1:0] OP_GT   = 2'd2;
   localparam logic [1:0] OP_LT   = 2'd3;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LESS   = 8'h3C;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_GREAT  = 8'h3E;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   function automatic logic [stt_pkg::KIND_W-1:0] op_kind(input logic [1:0] code);
      logic [stt_pkg::KIND_W-1:0] k;
      case (code)
         OP_EQ:   k = stt_pkg::K_EQUAL;
         OP_BANG: k = stt_pkg::K_BANG;
         OP_GT:   k = stt_pkg::K_GREATER;
         OP_LT:   k = stt_pkg::K_LESS;
         default: k = stt_pkg::K_EQUAL;
      endcase
      return k;
   endfunction

   mode_type                   mode_ff, mode_in;
   logic [1:0]                 op_ff, op_in;
   logic [stt_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [stt_pkg::POS_W-1:0]  start_ff, start_in;
   logic [7:0]                 prefix_ff [KEYWORD_SPAN];

   logic [7:0]                 b;
   logic                       is_digit, is_letter, accept;
   logic                       done, idle_has;
   logic [1:0]                 pre_cnt;
   stt_pkg::token_type         pre0, pre1, idle_tok;
   logic [stt_pkg::LEN_W-1:0]  cur_len;
   logic [stt_pkg::POS_W-1:0]  pos_back;
   logic [8*stt_pkg::KW_MAX_LEN-1:0] prefix_vec;
   logic                       pw_en;
   logic [KW_IDX_W-1:0]        pw_idx;

   assign b         = req_if.text_byte;
   assign is_digit  = (b >= 8'h30) && (b <= 8'h39);
   assign is_letter = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A))
                      || (b == 8'h5F);
   assign req_if.ready = !q_status.full;
   assign accept       = req_if.valid && req_if.ready;

   assign cur_len  = stt_pkg::span_len({1'b0, start_ff}, {1'b0, pos_ff});
   assign pos_back = stt_pkg::span_len(17'd1, {1'b0, pos_ff});

   always_comb begin
      for (int i = 0; i < stt_pkg::KW_MAX_LEN; i++) begin
         prefix_vec[8*i +: 8] = prefix_ff[i];
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      op_in    = op_ff;
      start_in = start_ff;
      pos_in   = (pos_ff < POS_LIMIT) ? pos_ff + 1'b1 : pos_ff;
      done     = 1'b0;
      pre_cnt  = 2'd0;
      pre0     = '0;
      pre1     = '0;
      idle_has = 1'b0;
      idle_tok = '0;
      pw_en    = 1'b0;
      pw_idx   = '0;

      // Close or extend the pending token
      case (mode_ff)
         MODE_OPER: begin
            if (b == CH_EQUAL) begin
               pre_cnt = 2'd1;
               pre0    = stt_pkg::make_token(op_kind(op_ff) + 1'b1, start_ff, 16'd2);
               mode_in = MODE_IDLE;
               done    = 1'b1;
            end else begin
               pre_cnt = 2'd1;
               pre0    = stt_pkg::make_token(op_kind(op_ff), start_ff, 16'd1);
            end
         end
         MODE_IDENT: begin
            if (is_letter || is_digit) begin
               done = 1'b1;
               if (cur_len < stt_pkg::LEN_W'(KEYWORD_SPAN)) begin
                  pw_en  = 1'b1;
                  pw_idx = cur_len[KW_IDX_W-1:0];
               end
            end else begin
               pre_cnt = 2'd1;
               pre0    = stt_pkg::make_token(stt_pkg::classify_ident(prefix_vec, cur_len),
                                             start_ff, cur_len);
            end
         end
         MODE_INT: begin
            if (is_digit) begin
               done = 1'b1;
            end else if (b == CH_DOT) begin
               mode_in = MODE_DOTWAIT;
               done    = 1'b1;
            end else begin
               pre_cnt = 2'd1;
               pre0    = stt_pkg::make_token(stt_pkg::K_NUMBER, start_ff, cur_len);
            end
         end
         MODE_DOTWAIT: begin
            if (is_digit) begin
               mode_in = MODE_FRAC;
               done    = 1'b1;
            end else begin
               // number without the held dot, then the dot on its own
               pre_cnt = 2'd2;
               pre0    = stt_pkg::make_token(stt_pkg::K_NUMBER, start_ff,
                            stt_pkg::span_len({1'b0, start_ff}, {1'b0, pos_back}));
               pre1    = stt_pkg::make_token(stt_pkg::K_DOT, pos_back, 16'd1);
            end
         end
         MODE_FRAC: begin
            if (is_digit) begin
               done = 1'b1;
            end else begin
               pre_cnt = 2'd1;
               pre0    = stt_pkg::make_token(stt_pkg::K_NUMBER, start_ff, cur_len);
            end
         end
         MODE_STRING: begin
            if (b == CH_QUOTE) begin
               pre_cnt = 2'd1;
               pre0    = stt_pkg::make_token(stt_pkg::K_STRING, start_ff,
                            stt_pkg::span_len({1'b0, start_ff}, {1'b0, pos_ff} + 17'd1));
               mode_in = MODE_IDLE;
               done    = 1'b1;
            end else if (b != CH_NUL) begin
               done = 1'b1;
            end else begin
               pre_cnt = 2'd1;
               pre0    = stt_pkg::make_token(stt_pkg::K_ERROR, start_ff, cur_len);
            end
         end
         default: ;
      endcase

      // Handle the byte from the idle state
      if (!done) begin
         mode_in = MODE_IDLE;
         case (b)
            CH_NUL: begin
               idle_has = 1'b1;
               idle_tok = stt_pkg::make_token(stt_pkg::K_EOF, pos_ff, 16'd0);
               op_in    = OP_EQ;
               pos_in   = '0;
               start_in = '0;
            end
            CH_SPACE, CH_TAB, CH_CR, CH_LF: ;
            CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_COMMA, CH_DOT,
            CH_MINUS, CH_PLUS, CH_SEMI, CH_SLASH, CH_STAR: begin
               idle_has = 1'b1;
               idle_tok.offset = pos_ff;
               idle_tok.length = 16'd1;
               case (b)
                  CH_LPAREN: idle_tok.kind = stt_pkg::K_LPAREN;
                  CH_RPAREN: idle_tok.kind = stt_pkg::K_RPAREN;
                  CH_LBRACE: idle_tok.kind = stt_pkg::K_LBRACE;
                  CH_RBRACE: idle_tok.kind = stt_pkg::K_RBRACE;
                  CH_COMMA:  idle_tok.kind = stt_pkg::K_COMMA;
                  CH_DOT:    idle_tok.kind = stt_pkg::K_DOT;
                  CH_MINUS:  idle_tok.kind = stt_pkg::K_MINUS;
                  CH_PLUS:   idle_tok.kind = stt_pkg::K_PLUS;
                  CH_SEMI:   idle_tok.kind = stt_pkg::K_SEMICOLON;
                  CH_SLASH:  idle_tok.kind = stt_pkg::K_SLASH;
                  default:   idle_tok.kind = stt_pkg::K_STAR;
               endcase
            end
            CH_EQUAL: begin
               mode_in = MODE_OPER; op_in = OP_EQ; start_in = pos_ff;
            end
            CH_BANG: begin
               mode_in = MODE_OPER; op_in = OP_BANG; start_in = pos_ff;
            end
            CH_GREAT: begin
               mode_in = MODE_OPER; op_in = OP_GT; start_in = pos_ff;
            end
            CH_LESS: begin
               mode_in = MODE_OPER; op_in = OP_LT; start_in = pos_ff;
            end
            CH_QUOTE: begin
               mode_in = MODE_STRING; start_in = pos_ff;
            end
            default: begin
               if (is_digit) begin
                  mode_in  = MODE_INT;
                  start_in = pos_ff;
               end else if (is_letter) begin
                  mode_in  = MODE_IDENT;
                  start_in = pos_ff;
                  pw_en    = 1'b1;
                  pw_idx   = '0;
               end else begin
                  idle_has = 1'b1;
                  idle_tok = stt_pkg::make_token(stt_pkg::K_ERROR, pos_ff, 16'd1);
               end
            end
         endcase
      end
   end

   // Pack pending-token results ahead of the idle result
   always_comb begin
      push_bundle.count   = pre_cnt + {1'b0, idle_has};
      push_bundle.toks[0] = (pre_cnt != 2'd0) ? pre0 : idle_tok;
      push_bundle.toks[1] = (pre_cnt == 2'd2) ? pre1 : idle_tok;
      push_bundle.toks[2] = idle_tok;
   end

   assign push = accept && (push_bundle.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         op_ff    <= OP_EQ;
         pos_ff   <= '0;
         start_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         op_ff    <= op_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pw_en) begin
         prefix_ff[pw_idx] <= b;
      end
   end

endmodule

/* design/stt_queue.sv */
// Short bundle queue decoupling the scanner from the token output.
module stt_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  stt_pkg::bundle_type       push_bundle,
   input  logic                      pop,
   output stt_pkg::bundle_type       head,
   output stt_pkg::queue_status_type status
);

   stt_pkg::bundle_type          entry_ff [stt_pkg::QUEUE_DEPTH];
   logic [stt_pkg::QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [stt_pkg::QCNT_W-1:0]   count_ff, count_in;

   assign status.full  = (count_ff == stt_pkg::QCNT_W'(stt_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

/* design/stt_back.sv */
// Token back end: walks each bundle and drives one token per transfer from an output register.
module stt_back (
   input  logic                      clock,
   input  logic                      reset,
   input  stt_pkg::bundle_type       head,
   input  stt_pkg::queue_status_type q_status,
   output logic                      pop,
   stt_rsp_if.source                 rsp_if
);

   logic               valid_ff, valid_in;
   stt_pkg::token_type tok_ff;
   logic               last_ff;
   logic [1:0]         idx_ff;
   logic               load, is_last;
   stt_pkg::token_type pick;

   assign load    = !q_status.empty && (!valid_ff || rsp_if.ready);
   assign is_last = (idx_ff == (head.count - 1'b1));
   assign pop     = load && is_last;

   always_comb begin
      case (idx_ff)
         2'd0:    pick = head.toks[0];
         2'd1:    pick = head.toks[1];
         default: pick = head.toks[2];
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            idx_ff <= is_last ? 2'd0 : idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff  <= pick;
         last_ff <= is_last;
      end
   end

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.token_kind   = tok_ff.kind;
   assign rsp_if.token_offset = tok_ff.offset;
   assign rsp_if.token_length = tok_ff.length;
   assign rsp_if.last_of_run  = last_ff;

endmodule

/* design/source_text_tokenizer.sv */
// Path: a token reaches rsp_if through a queue entry and then the output register after its byte's transfer.
// Throughput: one byte per cycle while the queue is not full; tokens leave at one per cycle from the
//   output register while rsp_if is ready; a four-bundle queue absorbs bursts.
// The scanner decides each byte combinationally from its state register; the output port sets the token rate.
// Reset: synchronous, active high; clears scan state, byte offset, queue and output valid.
// The keyword prefix store is not reset; only bytes written for the current identifier are read.
module source_text_tokenizer #(
   parameter int MAX_TEXT_BYTES = stt_pkg::MAX_TEXT_BYTES_DEF,
   parameter int KEYWORD_SPAN   = stt_pkg::KEYWORD_SPAN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   stt_req_if.sink    req_if,
   stt_rsp_if.source  rsp_if
);

   // Bundle handoff between front end and queue
   logic                      push;
   stt_pkg::bundle_type       push_bundle;

   // Queue head and status seen by both ends
   logic                      pop;
   stt_pkg::bundle_type       head;
   stt_pkg::queue_status_type q_status;

   // Classify each byte, close pending tokens, hold back when the queue is full
   stt_front #(
      .MAX_TEXT_BYTES (MAX_TEXT_BYTES),
      .KEYWORD_SPAN   (KEYWORD_SPAN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .q_status    (q_status),
      .push        (push),
      .push_bundle (push_bundle)
   );

   // Buffer bundles of up to three tokens so each side can stall on its own
   stt_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head        (head),
      .status      (q_status)
   );

   // Advance through each bundle, one token per transfer, marking the last one
   stt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

endmodule
